// ===== design/ssc_pkg.sv =====
// Shared types, constants and helpers for the servo sweep controller.
package ssc_pkg;

  // Command codes carried on the input tuser field
  typedef enum logic [2:0] {
    OP_TICK  = 3'd0,
    OP_SET   = 3'd1,
    OP_GLIDE = 3'd2,
    OP_OSC   = 3'd3,
    OP_STOP  = 3'd4
  } op_e;

  localparam logic [7:0] CenterOffset = 8'd90;
  localparam logic [7:0] AngleMax     = 8'd180;

  // One result item as it leaves the step logic
  typedef struct packed {
    logic       moving;
    logic       angle_written;
    logic [7:0] servo_angle;
  } res_t;

  // Offset a centre-relative angle by 90 and clamp to 0..180
  function automatic logic [7:0] to_servo(logic [7:0] rel);
    logic signed [8:0] sum;
    sum = $signed({rel[7], rel}) + $signed({1'b0, CenterOffset});
    if (sum < 9'sd0) begin
      return 8'd0;
    end else if (sum > $signed({1'b0, AngleMax})) begin
      return AngleMax;
    end else begin
      return sum[7:0];
    end
  endfunction

endpackage

// ===== design/servo_sweep_controller_unit.sv =====
// Top level of the servo sweep controller: input register, step core, result register.
//
//  Channel  | Direction | tdata (low bit up)             | tuser
//  s_axis   | in        | angle_a[7:0], angle_b[15:8]    | operation[2:0]
//  m_axis   | out       | servo_angle[7:0], angle_written[8], moving[9], zero[15:10] | -
//
// Each command passes through the input register and then the result
// register before its result appears on m_axis; one command is accepted
// per cycle while m_axis does not stall. The sweep state changes in the
// cycle a command moves from the input register to the result register.
// Reset leaves the angle at 90 degrees with no motion. A stall on m_axis
// holds both registers and backs up to s_axis_tready_o through the same chain.
module servo_sweep_controller_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [15:0] s_axis_tdata_i,  // angle_a[7:0], angle_b[15:8]
  input  logic [2:0]  s_axis_tuser_i,  // operation[2:0]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o   // servo_angle[7:0], angle_written[8], moving[9]
);

  logic          in_valid_q;
  logic [2:0]    op_q;
  logic [7:0]    angle_a_q, angle_b_q;
  logic          out_valid_q;
  ssc_pkg::res_t res_q;
  ssc_pkg::res_t res_d;
  logic          advance;

  // Hand a command on when the result register is free or being emptied
  assign advance         = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || advance;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      op_q      <= s_axis_tuser_i;
      angle_a_q <= s_axis_tdata_i[7:0];
      angle_b_q <= s_axis_tdata_i[15:8];
    end
  end

  ssc_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .commit_i  (advance),
    .op_i      (op_q),
    .angle_a_i (angle_a_q),
    .angle_b_i (angle_b_q),
    .result_o  (res_d)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!out_valid_q || m_axis_tready_i) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {6'd0, res_q.moving, res_q.angle_written, res_q.servo_angle};

endmodule

// ===== design/ssc_core.sv =====
// Sweep state registers and the combinational step logic for one command.
module ssc_core (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             commit_i,
  input  logic [2:0]       op_i,
  input  logic [7:0]       angle_a_i,
  input  logic [7:0]       angle_b_i,
  output ssc_pkg::res_t    result_o
);

  logic [7:0] angle_now_q, angle_now_d;
  logic [7:0] start_end_q, start_end_d;
  logic [7:0] target_end_q, target_end_d;
  logic       active_q, active_d;
  logic       single_q, single_d;

  logic [7:0] a_abs, b_abs, lo, hi, stepped;
  logic       written;

  // Convert the command angles to servo degrees
  assign a_abs = ssc_pkg::to_servo(angle_a_i);
  assign b_abs = ssc_pkg::to_servo(angle_b_i);
  assign lo    = (a_abs < b_abs) ? a_abs : b_abs;
  assign hi    = (a_abs < b_abs) ? b_abs : a_abs;

  // One degree toward the target end
  always_comb begin
    if (angle_now_q < target_end_q) begin
      stepped = angle_now_q + 8'd1;
    end else if (angle_now_q > target_end_q) begin
      stepped = angle_now_q - 8'd1;
    end else begin
      stepped = angle_now_q;
    end
  end

  // Work out the next state for the command in hand
  always_comb begin
    angle_now_d  = angle_now_q;
    start_end_d  = start_end_q;
    target_end_d = target_end_q;
    active_d     = active_q;
    single_d     = single_q;
    written      = 1'b0;
    case (ssc_pkg::op_e'(op_i))
      ssc_pkg::OP_TICK: begin
        if (active_q) begin
          angle_now_d = stepped;
          written     = (angle_now_q != target_end_q);
          if (stepped == target_end_q) begin
            if (single_q) begin
              active_d = 1'b0;
              single_d = 1'b0;
            end else begin
              start_end_d  = target_end_q;
              target_end_d = start_end_q;
            end
          end
        end
      end
      ssc_pkg::OP_SET: begin
        angle_now_d  = a_abs;
        start_end_d  = a_abs;
        target_end_d = a_abs;
        active_d     = 1'b0;
        single_d     = 1'b0;
        written      = 1'b1;
      end
      ssc_pkg::OP_GLIDE: begin
        start_end_d  = angle_now_q;
        target_end_d = a_abs;
        single_d     = 1'b1;
        active_d     = 1'b1;
      end
      ssc_pkg::OP_OSC: begin
        // Outside the range the nearer end wins; a tie is only possible when
        // both ends coincide, so either choice gives the same angle
        if (angle_now_q < lo) begin
          angle_now_d = lo;
          written     = 1'b1;
        end else if (angle_now_q > hi) begin
          angle_now_d = hi;
          written     = 1'b1;
        end
        start_end_d  = lo;
        target_end_d = hi;
        single_d     = 1'b0;
        active_d     = 1'b1;
      end
      ssc_pkg::OP_STOP: begin
        active_d = 1'b0;
        single_d = 1'b0;
      end
      default: begin
        // Unused codes leave everything as it is
      end
    endcase
  end

  assign result_o.servo_angle   = angle_now_d;
  assign result_o.angle_written = written;
  assign result_o.moving        = active_d;

  // Advance the state only when the command is handed on
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      angle_now_q  <= ssc_pkg::CenterOffset;
      start_end_q  <= ssc_pkg::CenterOffset;
      target_end_q <= ssc_pkg::CenterOffset;
      active_q     <= 1'b0;
      single_q     <= 1'b0;
    end else if (commit_i) begin
      angle_now_q  <= angle_now_d;
      start_end_q  <= start_end_d;
      target_end_q <= target_end_d;
      active_q     <= active_d;
      single_q     <= single_d;
    end
  end

  // The servo angle never leaves its mechanical range
  a_angle_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    angle_now_q <= ssc_pkg::AngleMax)
    else $error("servo angle beyond range");

  // A single move is always an active motion
  a_single_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    single_q |-> active_q)
    else $error("single move flagged while idle");

  // A tick while idle leaves the angle untouched
  a_idle_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (commit_i && op_i == ssc_pkg::OP_TICK && !active_q) |=> $stable(angle_now_q))
    else $error("idle tick moved the angle");

  // Stop always ends the motion
  a_stop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (commit_i && op_i == ssc_pkg::OP_STOP) |=> !active_q)
    else $error("stop left a motion active");

endmodule

// ===== tb/servo_sweep_controller_unit_checker.sv =====
// Checker for the servo sweep controller: predicts every result and compares it on m_axis.
module servo_sweep_controller_unit_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  input  logic        s_axis_tready_i,
  input  logic [15:0] s_axis_tdata_i,   // angle_a[7:0], angle_b[15:8]
  input  logic [2:0]  s_axis_tuser_i,   // operation[2:0]
  input  logic        m_axis_tvalid_i,
  input  logic        m_axis_tready_i,
  input  logic [15:0] m_axis_tdata_i,   // servo_angle[7:0], angle_written[8], moving[9]
  output int          mismatch_count_o,
  output int          pending_count_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ReportLimit = 10;

  // Predicted sweep state
  logic [7:0] pos_now;
  logic [7:0] sweep_from;
  logic [7:0] sweep_to;
  logic       in_motion;
  logic       glide_only;

  // Angles predicted for transfers still to come out of the block
  ssc_pkg::res_t expected_positions[$];
  int            mismatches;

  // Shift a centre-relative angle to servo degrees, saturating at both ends
  function automatic logic [7:0] centre_clamp(logic [7:0] rel);
    int deg;
    deg = $signed(rel) + int'(ssc_pkg::CenterOffset);
    if (deg < 0) begin
      deg = 0;
    end else if (deg > int'(ssc_pkg::AngleMax)) begin
      deg = int'(ssc_pkg::AngleMax);
    end
    return deg[7:0];
  endfunction

  // Apply one command to the predicted state and return the angle report it causes
  function automatic ssc_pkg::res_t sweep_step(logic [2:0] code, logic [7:0] raw_a,
                                               logic [7:0] raw_b);
    logic [7:0]    pos_a;
    logic [7:0]    pos_b;
    logic [7:0]    lo_end;
    logic [7:0]    hi_end;
    logic [7:0]    held;
    ssc_pkg::res_t rep;
    pos_a = centre_clamp(raw_a);
    pos_b = centre_clamp(raw_b);
    rep.angle_written = 1'b0;
    case (code)
      ssc_pkg::OP_TICK: begin
        if (in_motion) begin
          // Step one degree, unless already sitting on the target
          if (pos_now != sweep_to) begin
            pos_now = (pos_now < sweep_to) ? pos_now + 8'd1 : pos_now - 8'd1;
            rep.angle_written = 1'b1;
          end
          // At the target: finish a glide, or turn an oscillation round
          if (pos_now == sweep_to) begin
            if (glide_only) begin
              in_motion  = 1'b0;
              glide_only = 1'b0;
            end else begin
              held       = sweep_from;
              sweep_from = sweep_to;
              sweep_to   = held;
            end
          end
        end
      end
      ssc_pkg::OP_SET: begin
        pos_now    = pos_a;
        sweep_from = pos_a;
        sweep_to   = pos_a;
        in_motion  = 1'b0;
        glide_only = 1'b0;
        rep.angle_written = 1'b1;
      end
      ssc_pkg::OP_GLIDE: begin
        sweep_from = pos_now;
        sweep_to   = pos_a;
        glide_only = 1'b1;
        in_motion  = 1'b1;
      end
      ssc_pkg::OP_OSC: begin
        lo_end = (pos_a < pos_b) ? pos_a : pos_b;
        hi_end = (pos_a < pos_b) ? pos_b : pos_a;
        // Outside the range the near end is always strictly nearer; a tie needs equal ends
        if (pos_now < lo_end) begin
          pos_now = lo_end;
          rep.angle_written = 1'b1;
        end else if (pos_now > hi_end) begin
          pos_now = hi_end;
          rep.angle_written = 1'b1;
        end
        sweep_from = lo_end;
        sweep_to   = hi_end;
        glide_only = 1'b0;
        in_motion  = 1'b1;
      end
      ssc_pkg::OP_STOP: begin
        in_motion  = 1'b0;
        glide_only = 1'b0;
      end
      default: begin
        // Spare codes leave everything as it is
      end
    endcase
    rep.servo_angle = pos_now;
    rep.moving      = in_motion;
    return rep;
  endfunction

  // Count a failure and report the first few
  task automatic note_failure(string msg);
    if (mismatches < ReportLimit) begin
      $display("%0t checker: %s", $realtime, msg);
    end
    mismatches++;
  endtask

  // Compare outgoing transfers first, then predict the incoming one
  always @(posedge clk_i or negedge rst_ni) begin
    ssc_pkg::res_t seen;
    ssc_pkg::res_t want;
    if (!rst_ni) begin
      pos_now    = ssc_pkg::CenterOffset;
      sweep_from = ssc_pkg::CenterOffset;
      sweep_to   = ssc_pkg::CenterOffset;
      in_motion  = 1'b0;
      glide_only = 1'b0;
      expected_positions.delete();
      mismatches = 0;
    end else begin
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        seen = m_axis_tdata_i[9:0];
        if (expected_positions.size() == 0) begin
          note_failure($sformatf("unexpected transfer angle=%0d written=%0b moving=%0b",
                                 seen.servo_angle, seen.angle_written, seen.moving));
        end else begin
          want = expected_positions.pop_front();
          if (seen.servo_angle != want.servo_angle ||
              seen.angle_written != want.angle_written ||
              seen.moving != want.moving) begin
            note_failure($sformatf({"mismatch: expected angle=%0d written=%0b moving=%0b,",
                                    " got angle=%0d written=%0b moving=%0b"},
                                   want.servo_angle, want.angle_written, want.moving,
                                   seen.servo_angle, seen.angle_written, seen.moving));
          end
        end
      end
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        expected_positions.push_back(sweep_step(s_axis_tuser_i, s_axis_tdata_i[7:0],
                                                s_axis_tdata_i[15:8]));
      end
    end
    pending_count_o  = expected_positions.size();
    mismatch_count_o = mismatches;
  end

endmodule

// ===== tb/servo_sweep_controller_unit_tb.sv =====
// Testbench top for the servo sweep controller: clock, reset, command stimulus and verdict.
module servo_sweep_controller_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Command codes the block does not define
  localparam logic [2:0] OP_RSVD5 = 3'd5;
  localparam logic [2:0] OP_RSVD6 = 3'd6;
  localparam logic [2:0] OP_RSVD7 = 3'd7;

  localparam int WatchdogLimit  = 2000;
  localparam int DrainCycles    = 10;
  localparam int ItemsPerPhase  = 400;
  localparam int HoldCycles     = 300;

  logic        clk_i    = 1'b0;
  logic        rst_ni   = 1'b0;
  logic        s_tvalid = 1'b0;
  logic [15:0] s_tdata  = '0;
  logic [2:0]  s_tuser  = ssc_pkg::OP_TICK;
  logic        m_tready = 1'b0;
  logic        s_axis_tready_o;
  logic        m_axis_tvalid_o;
  logic [15:0] m_axis_tdata_o;

  int   mismatch_count;
  int   pending_count;
  int   gap_pct     = 0;
  int   stall_pct   = 0;
  int   hold_left   = 0;
  int   quiet_count = 0;
  logic hold_request = 1'b0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  servo_sweep_controller_unit dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_tvalid),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_tdata),
    .s_axis_tuser_i (s_tuser),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_tready),
    .m_axis_tdata_o (m_axis_tdata_o)
  );

  servo_sweep_controller_unit_checker sweep_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_i (s_axis_tready_o),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_i (m_axis_tvalid_o),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_i  (m_axis_tdata_o),
    .mismatch_count_o(mismatch_count),
    .pending_count_o (pending_count)
  );

  // Drive output back-pressure, with one long hold-off on request
  always @(posedge clk_i) begin
    if (hold_request && hold_left == 0) begin
      hold_left    = HoldCycles;
      hold_request = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // Abort when no transfer has happened for too long
  always @(posedge clk_i) begin
    if ((s_tvalid && s_axis_tready_o) || (m_axis_tvalid_o && m_tready)) begin
      quiet_count = 0;
    end else begin
      quiet_count++;
    end
    if (quiet_count >= WatchdogLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Offer one command, idling first at random, and return after its transfer
  task automatic send_command(input logic [2:0] code, input logic [7:0] ang_a,
                              input logic [7:0] ang_b);
    while ($urandom_range(0, 99) < gap_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= code;
    s_tdata  <= {ang_b, ang_a};
    @(negedge clk_i);
    while (!s_axis_tready_o) begin
      @(negedge clk_i);
    end
    @(posedge clk_i);
  endtask

  // Mostly angles within the servo range, sometimes any 8-bit pattern
  function automatic logic [7:0] random_angle();
    if ($urandom_range(0, 4) == 0) begin
      return 8'($urandom);
    end
    return 8'($urandom_range(0, 180) - 90);
  endfunction

  // Issue motion commands each followed by a run of ticks
  task automatic run_phase(input int sender_pct, input int receiver_pct, input int quota);
    int         done_count;
    int         pick;
    int         tick_run;
    logic [7:0] ang_a;
    logic [7:0] ang_b;
    gap_pct    = sender_pct;
    stall_pct  = receiver_pct;
    done_count = 0;
    while (done_count < quota) begin
      pick  = $urandom_range(0, 99);
      ang_a = random_angle();
      ang_b = random_angle();
      done_count++;
      if (pick < 15) begin
        send_command(ssc_pkg::OP_SET, ang_a, 8'($urandom));
      end else if (pick < 45) begin
        send_command(ssc_pkg::OP_GLIDE, ang_a, 8'($urandom));
      end else if (pick < 75) begin
        // Narrow ranges turn round often
        if ($urandom_range(0, 1) == 1) begin
          ang_b = ang_a + 8'($urandom_range(0, 8)) - 8'd4;
        end
        send_command(ssc_pkg::OP_OSC, ang_a, ang_b);
      end else if (pick < 88) begin
        send_command(ssc_pkg::OP_STOP, 8'($urandom), 8'($urandom));
      end else begin
        send_command(OP_RSVD5 + 3'($urandom_range(0, 2)), ang_a, ang_b);
        done_count--;
      end
      tick_run = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 8) : $urandom_range(10, 60);
      for (int i = 0; i < tick_run && done_count < quota; i++) begin
        send_command(ssc_pkg::OP_TICK, 8'($urandom), 8'($urandom));
        done_count++;
      end
    end
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: tick with no motion, then saturation at both ends
    send_command(ssc_pkg::OP_TICK, 8'h00, 8'h00);
    send_command(ssc_pkg::OP_SET, 8'h7F, 8'h00);
    send_command(ssc_pkg::OP_SET, 8'h80, 8'h7F);
    send_command(ssc_pkg::OP_SET, -8'sd90, 8'h00);
    send_command(ssc_pkg::OP_SET, 8'sd90, 8'h00);
    // Glide to where the servo already is: ends on the next tick without a write
    send_command(ssc_pkg::OP_GLIDE, 8'sd90, 8'h00);
    send_command(ssc_pkg::OP_TICK, 8'h00, 8'h00);
    // Short glide down, run past its end
    send_command(ssc_pkg::OP_GLIDE, 8'sd87, 8'h00);
    repeat (4) send_command(ssc_pkg::OP_TICK, 8'hFF, 8'hFF);
    // Stop a glide part way
    send_command(ssc_pkg::OP_GLIDE, 8'sd0, 8'h00);
    send_command(ssc_pkg::OP_TICK, 8'h00, 8'h00);
    send_command(ssc_pkg::OP_STOP, 8'h00, 8'h00);
    send_command(ssc_pkg::OP_TICK, 8'h00, 8'h00);
    // Oscillate starting above the range: jump to the high end, then turn round
    send_command(ssc_pkg::OP_OSC, -8'sd10, 8'sd10);
    send_command(ssc_pkg::OP_TICK, 8'h00, 8'h00);
    send_command(ssc_pkg::OP_TICK, 8'h00, 8'h00);
    // Ends given high first, at the field extremes
    send_command(ssc_pkg::OP_SET, 8'sd0, 8'h00);
    send_command(ssc_pkg::OP_OSC, 8'h7F, 8'h80);
    // Equal ends above the servo: jump onto them, then swap in place
    send_command(ssc_pkg::OP_SET, -8'sd60, 8'h00);
    send_command(ssc_pkg::OP_OSC, 8'sd5, 8'sd5);
    send_command(ssc_pkg::OP_TICK, 8'h00, 8'h00);
    // Spare codes
    send_command(OP_RSVD5, 8'hFF, 8'hFF);
    send_command(OP_RSVD6, 8'h00, 8'hFF);
    send_command(OP_RSVD7, 8'hFF, 8'h00);

    // Random phases; the first one starts with a long output hold-off
    hold_request = 1'b1;
    run_phase(0, 0, ItemsPerPhase);
    run_phase(78, 0, ItemsPerPhase);
    run_phase(0, 78, ItemsPerPhase);
    run_phase(24, 24, ItemsPerPhase);

    // Drain outstanding results
    s_tvalid <= 1'b0;
    while (pending_count != 0) begin
      @(negedge clk_i);
    end
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
